@@ rtl/core/fifo_with_delete_by_value_macros.svh @@
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value_macros.svh
// assertion macros for the queue rtl
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH
`define FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH

// condition implies consequence in the same cycle
`define FWDBV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define FWDBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fwdbv_pkg.sv @@
// ----------------------------------------------------------------------------
// fwdbv_pkg
// types and codes shared by the delete-by-value queue
// ----------------------------------------------------------------------------
package fwdbv_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_DEL = 2'd2
    } func_e;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_e;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // command transaction payload
    typedef struct packed {
        logic [1:0]         func;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // result transaction payload
    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] out_value;
        logic [COUNT_W-1:0] count;
    } result_t;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic enq_ok;
        logic deq_ok;
        logic del_go;
    } cell_ctrl_t;

endpackage

@@ rtl/core/fifo_with_delete_by_value.sv @@
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value
// bounded first-in first-out queue with enqueue, dequeue and delete of the
// first entry matching a value
// ----------------------------------------------------------------------------
// usage:
//   a command transaction (cmd.func, cmd.value) is taken at a rising edge
//   where start is high and busy is low. busy stays low, so a command can
//   be issued every cycle.
//   the result transaction appears on result in the cycle after the command
//   was taken, with done high for exactly that one cycle. the receiver
//   cannot stall; it must capture the result while done is high.
//   throughput is one command per cycle: the whole row of DEPTH cells
//   compares and shifts in parallel.
//   a delete compacts the entries behind the removed one, keeping order.
//   a zero value is null and is rejected for enqueue and delete.
//   reset empties the queue (count 0); stored words are not cleared and
//   are never read before being written.
// ----------------------------------------------------------------------------
`include "fifo_with_delete_by_value_macros.svh"

module fifo_with_delete_by_value #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fwdbv_pkg::cmd_t     cmd,
    output logic                done,
    output fwdbv_pkg::result_t  result
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic                  done_reg;
    fwdbv_pkg::result_t    result_reg;
    fwdbv_pkg::result_t    result_next;

    logic                  accept;
    logic [WIDTH-1:0]      key;
    logic                  key_nz;
    logic                  is_enq;
    logic                  is_deq;
    logic                  is_del;
    logic                  full;
    logic                  del_ok;
    fwdbv_pkg::cell_ctrl_t ctrl;

    logic [WIDTH-1:0]      cell_data [DEPTH];
    logic [DEPTH:0]        hit_chain;

    // one command per cycle, never stalled
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // decode
    assign key    = WIDTH'(cmd.value);
    assign key_nz = (key != '0);
    assign is_enq = accept && (cmd.func == fwdbv_pkg::FUNC_ENQ);
    assign is_deq = accept && (cmd.func == fwdbv_pkg::FUNC_DEQ);
    assign is_del = accept && (cmd.func == fwdbv_pkg::FUNC_DEL);
    assign full   = (occ_reg == CNT_W'(DEPTH));

    assign ctrl.enq_ok = is_enq && key_nz && !full;
    assign ctrl.deq_ok = is_deq && (occ_reg != '0);
    assign ctrl.del_go = is_del && key_nz;

    // cell row, head at index 0
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] nbr;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        fwdbv_cell #(
            .WIDTH (WIDTH),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key       (key),
            .count     (occ_reg),
            .hit_in    (hit_chain[i]),
            .next_data (nbr),
            .data      (cell_data[i]),
            .hit_out   (hit_chain[i+1])
        );
    end

    assign del_ok = hit_chain[DEPTH];

    // occupancy update
    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.enq_ok)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (ctrl.deq_ok || del_ok)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    // result formation
    always_comb
    begin
        result_next.status    = fwdbv_pkg::ST_REJECT;
        result_next.out_value = '0;
        result_next.count     = fwdbv_pkg::COUNT_W'(occ_next);
        if (ctrl.enq_ok || ctrl.deq_ok || del_ok)
        begin
            result_next.status = fwdbv_pkg::ST_OK;
        end
        else if (is_enq && key_nz && full)
        begin
            result_next.status = fwdbv_pkg::ST_FULL;
        end
        if (ctrl.deq_ok)
        begin
            result_next.out_value = fwdbv_pkg::VALUE_W'(cell_data[0]);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            done_reg <= accept;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `FWDBV_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= CNT_W'(DEPTH), "occupancy above depth")
    `FWDBV_ASSERT_NEXT(a_enq_grows, clk, rst_n, ctrl.enq_ok, (occ_reg == $past(occ_reg) + 1'b1) && done && (result.status == fwdbv_pkg::ST_OK), "enqueue did not grow queue")
    `FWDBV_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept, !done, "result without command")
    `FWDBV_ASSERT_SAME(a_fail_holds, clk, rst_n, done && (result.status != fwdbv_pkg::ST_OK), occ_reg == $past(occ_reg), "failed command changed count")
    `FWDBV_ASSERT_SAME(a_outv_ok, clk, rst_n, done && (result.out_value != '0), result.status == fwdbv_pkg::ST_OK, "data returned on failure")

endmodule

@@ rtl/core/fwdbv_cell.sv @@
// ----------------------------------------------------------------------------
// fwdbv_cell
// one queue slot: holds a word, compares it against the key and shifts
// toward the head when an entry at or before it is removed
// ----------------------------------------------------------------------------
module fwdbv_cell #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned CNT_W = 5,
    parameter int unsigned INDEX = 0
) (
    input  logic                  clk,
    input  fwdbv_pkg::cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]      key,
    input  logic [CNT_W-1:0]      count,
    input  logic                  hit_in,
    input  logic [WIDTH-1:0]      next_data,
    output logic [WIDTH-1:0]      data,
    output logic                  hit_out
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic             occupied;
    logic             match;
    logic             shift;
    logic             load;

    // slot holds a live entry when it lies below the fill count
    assign occupied = (count > CNT_W'(INDEX));
    assign match    = ctrl.del_go && occupied && (data_reg == key);
    assign hit_out  = hit_in | match;

    // shift on dequeue, or on delete at or ahead of this slot
    assign shift = ctrl.deq_ok | (ctrl.del_go & hit_out);
    assign load  = ctrl.enq_ok & (count == CNT_W'(INDEX));

    always_comb
    begin
        if (load)
        begin
            data_next = key;
        end
        else if (shift)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ test/queue_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queue_result_checker
// watches the command and result channels of the delete-by-value queue,
// keeps its own copy of the queue contents, predicts every result
// transaction and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module queue_result_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  fwdbv_pkg::cmd_t     cmd,
    input  logic                done,
    input  fwdbv_pkg::result_t  result,
    output int                  fail_count,
    output int                  pending,
    output int                  checked,
    output int                  ok_seen,
    output int                  reject_seen,
    output int                  full_seen,
    output int                  peak_held
);

    // shadow copy of the queue, entry 0 is the head
    logic [fwdbv_pkg::VALUE_W-1:0] words [DEPTH];
    int unsigned                   held;

    fwdbv_pkg::result_t predicted_results [$];
    fwdbv_pkg::result_t want;

    initial
    begin
        fail_count  = 0;
        checked     = 0;
        ok_seen     = 0;
        reject_seen = 0;
        full_seen   = 0;
        peak_held   = 0;
        held        = 0;
    end

    assign pending = predicted_results.size();

    // take out one entry and close the gap behind it
    function automatic void remove_word(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < held; i++)
            words[i] = words[i + 1];
        held--;
    endfunction

    // apply one command to the shadow queue and return its result
    function automatic fwdbv_pkg::result_t apply_queue_op(input fwdbv_pkg::cmd_t c);
        fwdbv_pkg::result_t r;
        int unsigned        i;
        logic               found;
        r.status    = fwdbv_pkg::ST_REJECT;
        r.out_value = '0;
        found       = 1'b0;
        case (c.func)
            fwdbv_pkg::FUNC_ENQ:
            begin
                // null is rejected before the full check
                if (c.value == '0)
                    r.status = fwdbv_pkg::ST_REJECT;
                else if (held >= DEPTH)
                    r.status = fwdbv_pkg::ST_FULL;
                else
                begin
                    words[held] = c.value;
                    held++;
                    r.status = fwdbv_pkg::ST_OK;
                end
            end
            fwdbv_pkg::FUNC_DEQ:
            begin
                if (held > 0)
                begin
                    r.out_value = words[0];
                    remove_word(0);
                    r.status = fwdbv_pkg::ST_OK;
                end
            end
            fwdbv_pkg::FUNC_DEL:
            begin
                // first match from the head wins
                if (c.value != '0)
                begin
                    for (i = 0; i < held && !found; i++)
                    begin
                        if (words[i] == c.value)
                        begin
                            remove_word(i);
                            found    = 1'b1;
                            r.status = fwdbv_pkg::ST_OK;
                        end
                    end
                end
            end
            default:
                r.status = fwdbv_pkg::ST_REJECT;
        endcase
        r.count = held[fwdbv_pkg::COUNT_W-1:0];
        if (int'(held) > peak_held)
            peak_held = held;
        return r;
    endfunction

    // count a failure, report only the first few
    task automatic note_mismatch(input fwdbv_pkg::result_t expected_r,
                                 input fwdbv_pkg::result_t got);
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch: expected status %0d out_value %h count %0d, got status %0d out_value %h count %0d",
                         $time, expected_r.status, expected_r.out_value, expected_r.count,
                         got.status, got.out_value, got.count);
        end
    endtask

    // predict on every accepted command, check on every result transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            predicted_results.delete();
        end
        else
        begin
            if (start && !busy)
                predicted_results.push_back(apply_queue_op(cmd));
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected result: status %0d out_value %h count %0d",
                                 $time, result.status, result.out_value, result.count);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    checked++;
                    case (want.status)
                        fwdbv_pkg::ST_OK:   ok_seen++;
                        fwdbv_pkg::ST_FULL: full_seen++;
                        default:            reject_seen++;
                    endcase
                    if (result.status !== want.status
                        || result.out_value !== want.out_value
                        || result.count !== want.count)
                        note_mismatch(want, result);
                end
            end
        end
    end

endmodule

@@ test/tb_fifo_with_delete_by_value.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_with_delete_by_value
// drives enqueue, dequeue and delete commands into the queue: a directed
// pass over the empty, full, null and no-match cases, then three random
// phases with different sender idling, while the checker predicts and
// compares every result transaction
// ----------------------------------------------------------------------------
module tb_fifo_with_delete_by_value;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         PHASE_ITEMS    = 474;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    fwdbv_pkg::cmd_t    cmd   = '0;
    logic               busy;
    logic               done;
    fwdbv_pkg::result_t result;

    int fail_count;
    int pending;
    int checked;
    int ok_seen;
    int reject_seen;
    int full_seen;
    int peak_held;
    int sent        = 0;
    int idle_cycles = 0;

    fifo_with_delete_by_value i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    queue_result_checker #(
        .DEPTH (16)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .ok_seen     (ok_seen),
        .reject_seen (reject_seen),
        .full_seen   (full_seen),
        .peak_held   (peak_held)
    );

    // clock
    always #10 clk = ~clk;

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || done))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // hold one command transaction until it is taken
    task automatic issue(input logic [1:0] f, input logic [fwdbv_pkg::VALUE_W-1:0] v);
        begin
            start <= 1'b1;
            cmd   <= {f, v};
            do
                @(posedge clk);
            while (busy);
            sent++;
        end
    endtask

    // random sender idling, pct in a hundred per cycle
    task automatic gap(input int pct);
        begin
            while ($urandom_range(99) < pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // stop sending until every expected result has come back
    task automatic drain();
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending != 0)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    // small pool for frequent delete hits, plus null, high words and full range
    function automatic logic [fwdbv_pkg::VALUE_W-1:0] pick_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        else if (pick < 70)
            return $urandom_range(12, 1);
        else if (pick < 80)
            return 32'hFFFF_FFF0 | $urandom_range(15);
        else
            return $urandom;
    endfunction

    initial
    begin
        int          phase;
        int          n;
        int          idle_pct;
        int          enq_weight;
        int unsigned roll;
        logic [1:0]  f;

        enq_weight = 45;

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty, null and unknown operation
        issue(fwdbv_pkg::FUNC_DEQ, '0);
        issue(fwdbv_pkg::FUNC_DEL, 32'd5);
        issue(fwdbv_pkg::FUNC_ENQ, '0);
        issue(fwdbv_pkg::FUNC_DEL, '0);
        issue(FUNC_UNUSED, 32'hFFFF_FFFF);
        // only entry removed by dequeue and by delete
        issue(fwdbv_pkg::FUNC_ENQ, 32'hFFFF_FFFF);
        issue(fwdbv_pkg::FUNC_DEQ, '0);
        issue(fwdbv_pkg::FUNC_ENQ, 32'd9);
        issue(fwdbv_pkg::FUNC_DEL, 32'd9);
        // fill to the top with duplicates of 7
        for (n = 0; n < 16; n++)
            issue(fwdbv_pkg::FUNC_ENQ, (n % 4 == 1) ? 32'd7 : (32'h8000_0000 | n));
        // full, null on full, first-match delete, no match
        issue(fwdbv_pkg::FUNC_ENQ, 32'h1234_5678);
        issue(fwdbv_pkg::FUNC_ENQ, '0);
        issue(fwdbv_pkg::FUNC_DEL, 32'd7);
        issue(fwdbv_pkg::FUNC_DEL, 32'h5555_5555);
        drain();

        // random phases: sender idles 35, then 71, then never
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 35 : (phase == 1) ? 71 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // swing between filling and emptying runs
                if (n % 40 == 0)
                    enq_weight = 25 + 20 * $urandom_range(2);
                gap(idle_pct);
                roll = $urandom_range(99);
                if (roll < 3)
                    f = FUNC_UNUSED;
                else if (roll < 3 + enq_weight)
                    f = fwdbv_pkg::FUNC_ENQ;
                else if (roll < 3 + enq_weight + (97 - enq_weight) / 2)
                    f = fwdbv_pkg::FUNC_DEQ;
                else
                    f = fwdbv_pkg::FUNC_DEL;
                issue(f, pick_value());
            end
            drain();
        end

        // let any stray result show up
        repeat (4) @(negedge clk);

        $display("covered %0d commands, %0d results checked: %0d ok, %0d rejected, %0d full",
                 sent, checked, ok_seen, reject_seen, full_seen);
        $display("peak occupancy %0d, sender idling 35/71/0 per hundred cycles", peak_held);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
